[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the merge sort engine.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/mse_pkg.sv]
// Package of the merge sort engine: sizes, the data type and the cell control struct.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mse_pkg;
    localparam int LIST_SIZE = 64;
    localparam int DATA_W    = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;
endpackage
`default_nettype wire

[rtl/merge_sort_engine_top.sv]
// A list loads one request per cycle, and the smallest value is offered in the
// cycle after the closing request is taken. Draining gives one sorted value per
// cycle while m_tready is high. Each request is placed in order by a broadcast
// compare across the cell chain; with the last cell taken it is dropped instead.
// Reset clears every valid bit, the overflow flag and the sequencer to loading.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module merge_sort_engine_top (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire  [mse_pkg::DATA_W-1:0] s_tdata,   // value
    input  wire                       s_tlast,   // last
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [mse_pkg::DATA_W-1:0] m_tdata,   // sorted_value
    output logic                      m_tlast,   // last_res
    output logic                      m_tuser    // dropped
);
    import mse_pkg::*;

    data_t      cell_value [LIST_SIZE];
    logic       cell_valid [LIST_SIZE];
    logic       cell_gt    [LIST_SIZE];
    cell_ctrl_t cell_ctrl;
    data_t      new_value;
    logic       full;
    logic       out_is_last;

    assign new_value   = data_t'(s_tdata);
    assign full        = cell_valid[LIST_SIZE-1];
    assign out_is_last = !cell_valid[1];

    mse_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_last     (s_tlast),
        .full        (full),
        .out_ready   (m_tready),
        .out_is_last (out_is_last),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid),
        .dropped     (m_tuser),
        .cell_ctrl   (cell_ctrl)
    );

    for (genvar i = 0; i < LIST_SIZE; i++)
    begin : g_cell
        logic  left_gt;
        data_t left_value;
        logic  left_valid;
        data_t right_value;
        logic  right_valid;

        if (i == 0)
        begin : g_first
            assign left_gt    = 1'b0;
            assign left_value = '0;
            assign left_valid = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_gt    = cell_gt[i-1];
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == LIST_SIZE - 1)
        begin : g_end
            assign right_value = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        mse_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .new_value   (new_value),
            .left_gt     (left_gt),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .right_value (right_value),
            .right_valid (right_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i])
        );
    end

    assign m_tdata = cell_value[0];
    assign m_tlast = out_is_last;

    `ASSERT_ALWAYS(a_load_drain_exclusive, clk, rst_n, !(s_tready && m_tvalid))
    `ASSERT_ALWAYS(a_drain_not_empty, clk, rst_n, !m_tvalid || cell_valid[0])
    `ASSERT_ALWAYS(a_head_in_order, clk, rst_n,
        !(m_tvalid && cell_valid[1]) || (cell_value[0] <= cell_value[1]))
    `ASSERT_NEXT(a_close_starts_drain, clk, rst_n, s_tvalid && s_tready && s_tlast, m_tvalid)
    `ASSERT_NEXT(a_end_returns_load, clk, rst_n, m_tvalid && m_tready && m_tlast,
        s_tready && !cell_valid[0])
endmodule
`default_nettype wire

[rtl/mse_cell.sv]
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on mse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mse_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mse_pkg::cell_ctrl_t ctrl,
    input  mse_pkg::data_t      new_value,
    input  wire                 left_gt,
    input  mse_pkg::data_t      left_value,
    input  wire                 left_valid,
    input  mse_pkg::data_t      right_value,
    input  wire                 right_valid,
    output mse_pkg::data_t      value,
    output logic                valid,
    output logic                gt
);
    import mse_pkg::*;

    data_t value_reg;
    data_t value_next;
    logic  valid_reg;
    logic  valid_next;

    // A free cell counts as greater, so a value above all stored ones lands in the first free cell.
    assign gt = !valid_reg || (value_reg > new_value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (left_gt)
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            else if (gt)
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
endmodule
`default_nettype wire

[rtl/mse_ctrl.sv]
// Load and drain sequencer of the merge sort engine, with the sticky overflow flag.
// Depends on mse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mse_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 in_last,
    input  wire                 full,
    input  wire                 out_ready,
    input  wire                 out_is_last,
    output logic                in_ready,
    output logic                out_valid,
    output logic                dropped,
    output mse_pkg::cell_ctrl_t cell_ctrl
);
    import mse_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   overflow_reg;
    logic   overflow_next;
    logic   in_fire;
    logic   out_fire;

    assign in_fire  = in_valid && in_ready_reg;
    assign out_fire = out_valid_reg && out_ready;

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        overflow_next  = overflow_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    overflow_next = overflow_reg || full;
                    if (in_last)
                    begin
                        state_next     = ST_DRAIN;
                        in_ready_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_fire && out_is_last)
                begin
                    state_next     = ST_LOAD;
                    in_ready_next  = 1'b1;
                    out_valid_next = 1'b0;
                    overflow_next  = 1'b0;
                end
            end
            default:
            begin
                state_next     = ST_LOAD;
                in_ready_next  = 1'b1;
                out_valid_next = 1'b0;
                overflow_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
            overflow_reg  <= overflow_next;
        end
    end

    assign cell_ctrl.insert = in_fire && !full;
    assign cell_ctrl.shift  = out_fire;
    assign in_ready         = in_ready_reg;
    assign out_valid        = out_valid_reg;
    assign dropped          = overflow_reg;
endmodule
`default_nettype wire
